>>> design/polc_pkg.sv
// shared types, constants and arithmetic helpers for the point-on-line jacobian block
`timescale 1ns / 1ps
`default_nettype none
package polc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TRIG_STAGES = 16;
	localparam int TRIG_FRAC = 30;
	localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
	localparam int NUM_REGS = 6;
	localparam int ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_DIR_X    = 3'd2,
		REG_DIR_Y    = 3'd3,
		REG_ANCHOR_X = 3'd4,
		REG_ANCHOR_Y = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] anchor_x;
		logic signed [31:0] anchor_y;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] rate;
	} body_t;

	// cordic angle table, 32 bit residual scale
	function automatic logic signed [33:0] atan_val(input int i);
		logic signed [33:0] r;
		unique case (i)
			0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
			3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
			6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
			9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
			12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
			15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
			18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
			21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
			24: r = 34'sd41;        25: r = 34'sd20;        26: r = 34'sd10;
			27: r = 34'sd5;         28: r = 34'sd3;         29: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) r = 32'sh7fffffff;
		else if (v < -68'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// round half up of an exact sum, arithmetic shift by sh
	function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int sh);
		logic signed [67:0] half;
		half = 68'sd1 <<< (sh - 1);
		return (v + half) >>> sh;
	endfunction

endpackage
`default_nettype wire

>>> design/polc_cordic.sv
// pipelined rotation-mode cordic producing cosine and sine with 30 fraction bits
`timescale 1ns / 1ps
`default_nettype none
module polc_cordic (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [31:0]         angle,
	input  wire polc_pkg::body_t     in_body,
	output logic                     out_valid,
	output logic signed [33:0]       cos_o,
	output logic signed [33:0]       sin_o,
	output polc_pkg::body_t          out_body
);
	localparam int N = polc_pkg::TRIG_STAGES;

	logic signed [33:0] x_s [N+1];
	logic signed [33:0] y_s [N+1];
	logic signed [33:0] z_s [N+1];
	logic [1:0]         quad_s [N+1];
	polc_pkg::body_t    body_s [N+1];
	logic [N:0]         vld_s;

	logic [31:0] t_ang;
	logic [31:0] ru;
	assign t_ang = angle + 32'h2000_0000;
	assign ru = angle - {t_ang[31:30], 30'd0};

	assign x_s[0] = polc_pkg::INV_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = {{2{ru[31]}}, ru};
	assign quad_s[0] = t_ang[31:30];
	assign body_s[0] = in_body;
	assign vld_s[0] = in_valid;

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - polc_pkg::atan_val(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + polc_pkg::atan_val(i);
				end
				quad_s[i+1] <= quad_s[i];
				body_s[i+1] <= body_s[i];
			end
		end
	end

	always_comb begin
		unique case (quad_s[N])
			2'd0: begin cos_o = x_s[N]; sin_o = y_s[N]; end
			2'd1: begin cos_o = -y_s[N]; sin_o = x_s[N]; end
			2'd2: begin cos_o = -x_s[N]; sin_o = -y_s[N]; end
			default: begin cos_o = y_s[N]; sin_o = -x_s[N]; end
		endcase
	end
	assign out_valid = vld_s[N];
	assign out_body = body_s[N];
endmodule
`default_nettype wire

>>> design/polc_geom.sv
// rotation, offset and dot-product pipeline after the cordic
`timescale 1ns / 1ps
`default_nettype none
module polc_geom (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire polc_pkg::cfg_t      cfg,
	input  wire logic                in_valid,
	input  wire logic signed [33:0]  cos_i,
	input  wire logic signed [33:0]  sin_i,
	input  wire polc_pkg::body_t     in_body,
	output logic                     out_valid,
	output logic [159:0]             result
);
	localparam int F = polc_pkg::FRAC_BITS;
	localparam int T = polc_pkg::TRIG_FRAC;

	// s1: four rotation products
	logic signed [67:0] p_cx_s1, p_sy_s1, p_sx_s1, p_cy_s1;
	polc_pkg::body_t b_s1;
	// s2: rotated anchor
	logic signed [31:0] rx_s2, ry_s2;
	polc_pkg::body_t b_s2;
	// s3: offset from origin
	logic signed [31:0] dfx_s3, dfy_s3, rx_s3, ry_s3, w_s3;
	// s4: products with the line
	logic signed [67:0] e1_s4, e2_s4, j1_s4, j2_s4, u1_s4, u2_s4;
	logic signed [31:0] w_s4;
	// s5: sums
	logic signed [31:0] err_s5, jang_s5, u_s5, w_s5;
	// s6: rate product
	logic signed [67:0] jd_s6;
	logic signed [31:0] err_s6, jang_s6;
	logic [5:0] vld_q;

	logic signed [32:0] ndy;
	assign ndy = -{cfg.dir_y[31], cfg.dir_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_cx_s1 <= 68'(cos_i) * 68'(cfg.anchor_x);
			p_sy_s1 <= 68'(sin_i) * 68'(cfg.anchor_y);
			p_sx_s1 <= 68'(sin_i) * 68'(cfg.anchor_x);
			p_cy_s1 <= 68'(cos_i) * 68'(cfg.anchor_y);
			b_s1 <= in_body;

			rx_s2 <= polc_pkg::sat32(polc_pkg::rnd(p_cx_s1 - p_sy_s1, T));
			ry_s2 <= polc_pkg::sat32(polc_pkg::rnd(p_sx_s1 + p_cy_s1, T));
			b_s2 <= b_s1;

			dfx_s3 <= polc_pkg::sat32(68'(polc_pkg::sat32(68'(b_s2.pos_x) + 68'(rx_s2)))
				- 68'(cfg.origin_x));
			dfy_s3 <= polc_pkg::sat32(68'(polc_pkg::sat32(68'(b_s2.pos_y) + 68'(ry_s2)))
				- 68'(cfg.origin_y));
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
			w_s3 <= b_s2.rate;

			e1_s4 <= 68'(dfx_s3) * 68'(ndy);
			e2_s4 <= 68'(dfy_s3) * 68'(cfg.dir_x);
			j1_s4 <= 68'(rx_s3) * 68'(cfg.dir_x);
			j2_s4 <= 68'(ry_s3) * 68'(cfg.dir_y);
			u1_s4 <= 68'(rx_s3) * 68'(ndy);
			u2_s4 <= 68'(ry_s3) * 68'(cfg.dir_x);
			w_s4 <= w_s3;

			err_s5 <= polc_pkg::sat32(polc_pkg::rnd(e1_s4 + e2_s4, F));
			jang_s5 <= polc_pkg::sat32(polc_pkg::rnd(j1_s4 + j2_s4, F));
			u_s5 <= polc_pkg::sat32(polc_pkg::rnd(u1_s4 + u2_s4, F));
			w_s5 <= w_s4;

			jd_s6 <= -(68'(w_s5) * 68'(u_s5));
			err_s6 <= err_s5;
			jang_s6 <= jang_s5;
		end
	end

	logic signed [31:0] jx, jdot;
	assign jx = polc_pkg::sat32(68'(ndy));
	assign jdot = polc_pkg::sat32(polc_pkg::rnd(jd_s6, F));
	assign result = {jdot, jang_s6, cfg.dir_x, jx, err_s6};
	assign out_valid = vld_q[5];
endmodule
`default_nettype wire

>>> design/point_on_line_constraint_jacobian.sv
// top level: apb register file, stall control, output register
`timescale 1ns / 1ps
`default_nettype none
// When not stalled, one request per clock enters TRIG_STAGES (16) cordic
// stages and six arithmetic stages, then an output register, for one item
// per cycle of throughput. The whole pipeline advances whenever the output
// register is empty or being drained, so downstream stalls hold every
// stage in place. Registers must be written while the block is idle.
module point_on_line_constraint_jacobian (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [polc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// body_pos_x, body_pos_y, body_angle, angular_rate
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// constraint_error, jac_x, jac_y, jac_angle, jac_dot_angle
	output logic [159:0]      m_tdata
);
	polc_pkg::cfg_t cfg_q;
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (ridx)
				polc_pkg::REG_ORIGIN_X: cfg_q.origin_x <= pwdata;
				polc_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= pwdata;
				polc_pkg::REG_DIR_X:    cfg_q.dir_x <= pwdata;
				polc_pkg::REG_DIR_Y:    cfg_q.dir_y <= pwdata;
				polc_pkg::REG_ANCHOR_X: cfg_q.anchor_x <= pwdata;
				polc_pkg::REG_ANCHOR_Y: cfg_q.anchor_y <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			polc_pkg::REG_ORIGIN_X: prdata = cfg_q.origin_x;
			polc_pkg::REG_ORIGIN_Y: prdata = cfg_q.origin_y;
			polc_pkg::REG_DIR_X:    prdata = cfg_q.dir_x;
			polc_pkg::REG_DIR_Y:    prdata = cfg_q.dir_y;
			polc_pkg::REG_ANCHOR_X: prdata = cfg_q.anchor_x;
			polc_pkg::REG_ANCHOR_Y: prdata = cfg_q.anchor_y;
			default: prdata = '0;
		endcase
	end

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	polc_pkg::body_t in_body, c_body;
	assign in_body.pos_x = s_tdata[31:0];
	assign in_body.pos_y = s_tdata[63:32];
	assign in_body.rate = s_tdata[127:96];

	logic c_valid, g_valid;
	logic signed [33:0] c_cos, c_sin;
	logic [159:0] g_res;

	polc_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_tvalid), .angle(s_tdata[95:64]), .in_body(in_body),
		.out_valid(c_valid), .cos_o(c_cos), .sin_o(c_sin), .out_body(c_body)
	);

	polc_geom u_geom (
		.clk(clk), .arst_n(arst_n), .en(en), .cfg(cfg_q),
		.in_valid(c_valid), .cos_i(c_cos), .sin_i(c_sin), .in_body(c_body),
		.out_valid(g_valid), .result(g_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= g_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= g_res;
		end
	end
endmodule
`default_nettype wire
